FILE: sv/ppp_pkg.sv
// Shared types and constants of the perspective point projection block.
// No dependencies; imported by every module of the block.
`default_nettype none
package ppp_pkg;

    localparam int COEF_COUNT = 16;
    localparam int COEF_AW    = 4;
    localparam int NDC_BITS   = 40;
    localparam int QDEPTH     = 2;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 17;
    localparam logic [CFG_IW-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_NEAR_LIMIT    = 2'd2;

    localparam logic [13:0] RST_SCREEN_WIDTH  = 14'd1024;
    localparam logic [13:0] RST_SCREEN_HEIGHT = 14'd768;
    localparam logic [16:0] RST_NEAR_LIMIT    = 17'd6554;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [3:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_TRANS,
        ST_TEST,
        ST_DPREP,
        ST_DIV,
        ST_MAP,
        ST_SUM,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

FILE: sv/perspective_point_projection.sv
// Top level of the perspective point projection block: configuration
// registers, front queue and back end. Depends on ppp_pkg, ppp_front, ppp_back.
//
// Load items (operation 0) write one coefficient of the 4x4 column-major
// Q16.16 matrix and give no result beat; project items (operation 1) give one
// result beat each. A point whose clip w falls below near_limit (or is not
// positive) comes out with visible low and zero coordinates; otherwise x and y
// are divided by w and mapped to the viewport, saturated to 32 bits. Both
// sides look like queues: push/full in, empty/pop out. The front holds up to
// two items, so input beats are taken while the back works and while a result
// waits. The back does one item at a time: a load is written while it stays
// idle, a hidden point needs only the w clip row, and a visible point needs
// three clip rows of the shared multiply-accumulate and the radix-2 divider
// that runs both quotients side by side. Configuration writes take effect at
// once and are meant for idle periods.
`default_nettype none
module perspective_point_projection #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic                       i_operation,
    input  wire logic [3:0]                 i_coef_index,
    input  wire logic signed [31:0]         i_coef_value,
    input  wire logic signed [31:0]         i_pos_x,
    input  wire logic signed [31:0]         i_pos_y,
    input  wire logic signed [31:0]         i_pos_z,
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            o_visible,
    output logic signed [31:0]              o_screen_x,
    output logic signed [31:0]              o_screen_y,
    input  wire logic                       i_cfg_we,
    input  wire logic [ppp_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [ppp_pkg::CFG_DW-1:0] i_cfg_data
);
    import ppp_pkg::*;

    logic [13:0] r_screen_width, r_screen_height;
    logic [16:0] r_near_limit;
    t_item       w_item, w_head;
    logic        w_head_valid, w_head_pop;

    // configuration registers; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_near_limit    <= RST_NEAR_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[13:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[13:0];
                CFG_NEAR_LIMIT:    r_near_limit    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // gather the input beat into one item
    always_comb begin
        w_item.operation  = i_operation;
        w_item.coef_index = i_coef_index;
        w_item.coef_value = i_coef_value;
        w_item.pos_x      = i_pos_x;
        w_item.pos_y      = i_pos_y;
        w_item.pos_z      = i_pos_z;
    end

    ppp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_item       (w_item),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_head_pop   (w_head_pop)
    );

    ppp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_head_valid    (w_head_valid),
        .o_head_pop      (w_head_pop),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .i_near_limit    (r_near_limit),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_visible       (o_visible),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y)
    );

endmodule
`default_nettype wire

FILE: sv/ppp_front.sv
// Front end: accepts items, classifies them and holds them in a short queue.
// Depends on ppp_pkg.
`default_nettype none
module ppp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire ppp_pkg::t_item i_item,
    output ppp_pkg::t_item     o_head,
    output logic               o_head_valid,
    input  wire logic          i_head_pop
);
    import ppp_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_item            r_mem [QDEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [PW:0]      r_count;
    t_item            w_clean;
    logic             w_push, w_pop;

    assign o_full       = (r_count == (PW+1)'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rptr];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_head_pop && o_head_valid;

    // drop the fields the item's kind does not use
    always_comb begin
        w_clean = i_item;
        if (i_item.operation == OP_LOAD) begin
            w_clean.pos_x = '0;
            w_clean.pos_y = '0;
            w_clean.pos_z = '0;
        end else begin
            w_clean.coef_index = '0;
            w_clean.coef_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_clean;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PW+1)'(QDEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_head_pop) |=> o_full)
        else $error("queue lost an entry while full");

endmodule
`default_nettype wire

FILE: sv/ppp_back.sv
// Back end: coefficient store, shared multiply-accumulate, two-lane divider,
// viewport mapping and the result register. Depends on ppp_pkg.
`default_nettype none
module ppp_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ppp_pkg::t_item i_head,
    input  wire logic           i_head_valid,
    output logic                o_head_pop,
    input  wire logic [13:0]    i_screen_width,
    input  wire logic [13:0]    i_screen_height,
    input  wire logic [16:0]    i_near_limit,
    output logic                o_empty,
    input  wire logic           i_pop,
    output logic                o_visible,
    output logic signed [31:0]  o_screen_x,
    output logic signed [31:0]  o_screen_y
);
    import ppp_pkg::*;

    localparam int CW  = 67;
    localparam int DW  = CW + NDC_BITS + 1;
    localparam int NW  = NDC_BITS + 2;
    localparam int HW  = 14;
    localparam int PRW = HW + NW;
    localparam int SW  = PRW + 1;
    localparam int CNW = $clog2(NDC_BITS + 2);

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        logic signed [31:0] res;
        if (v > SW'(signed'(32'sh7FFF_FFFF))) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < SW'(signed'(32'sh8000_0000))) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    t_state              r_state, n_state;
    logic signed [31:0]  r_coef [COEF_COUNT];
    logic signed [31:0]  r_pos_x, r_pos_y, r_pos_z;
    logic [1:0]          r_row, r_k;
    logic signed [63:0]  r_prod;
    logic signed [CW-1:0] r_acc, r_cw, r_cx, r_cy;
    logic [DW-1:0]       r_rx, r_ry, r_wsh;
    logic                r_negx, r_negy;
    logic [NDC_BITS:0]   r_qx, r_qy;
    logic [CNW-1:0]      r_cnt;
    logic signed [PRW-1:0] r_px, r_py;
    logic                r_res_vis;
    logic signed [31:0]  r_res_x, r_res_y;
    logic                r_ov, r_ovis;
    logic signed [31:0]  r_ox, r_oy;

    logic signed [31:0]  w_pos, w_coef, w_trans;
    logic signed [CW-1:0] w_clip;
    logic                w_vis, w_bx, w_by, w_slot;
    logic [CW-1:0]       w_magx, w_magy;
    logic [NDC_BITS:0]   w_nmx, w_nmy;
    logic signed [NW-1:0] w_nx, w_ny;
    logic signed [HW-1:0] w_hw, w_hh;
    logic signed [SW-1:0] w_sx, w_sy;

    assign o_empty    = !r_ov;
    assign o_visible  = r_ovis;
    assign o_screen_x = r_ox;
    assign o_screen_y = r_oy;
    assign w_slot     = !r_ov || i_pop;

    always_comb begin
        case (r_k)
            2'd0:    w_pos = r_pos_x;
            2'd1:    w_pos = r_pos_y;
            default: w_pos = r_pos_z;
        endcase
    end
    assign w_coef  = r_coef[{r_k, r_row}];
    assign w_trans = r_coef[{2'b11, r_row}];
    assign w_clip  = (r_acc >>> FRAC_BITS) + CW'(w_trans);
    assign w_vis   = (r_cw > 0) && (r_cw >= $signed(CW'(i_near_limit)));

    assign w_magx = r_cx[CW-1] ? CW'(-r_cx) : CW'(r_cx);
    assign w_magy = r_cy[CW-1] ? CW'(-r_cy) : CW'(r_cy);
    assign w_bx   = (r_rx >= r_wsh);
    assign w_by   = (r_ry >= r_wsh);

    // cap the quotient at 2^40 when the top bit came out set
    assign w_nmx = r_qx[NDC_BITS] ? {1'b1, NDC_BITS'(0)} : {1'b0, r_qx[NDC_BITS-1:0]};
    assign w_nmy = r_qy[NDC_BITS] ? {1'b1, NDC_BITS'(0)} : {1'b0, r_qy[NDC_BITS-1:0]};
    assign w_nx  = r_negx ? -$signed(NW'(w_nmx)) : $signed(NW'(w_nmx));
    assign w_ny  = r_negy ? -$signed(NW'(w_nmy)) : $signed(NW'(w_nmy));
    assign w_hw  = $signed({1'b0, i_screen_width[13:1]});
    assign w_hh  = $signed({1'b0, i_screen_height[13:1]});
    assign w_sx  = SW'(r_px) + (SW'(w_hw) <<< FRAC_BITS);
    assign w_sy  = (SW'(w_hh) <<< FRAC_BITS) - SW'(r_py);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_head_valid && i_head.operation == OP_PROJECT) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_ACC;
            ST_ACC:   n_state = (r_k == 2'd2) ? ST_TRANS : ST_MUL;
            ST_TRANS: n_state = (r_row == 2'd3) ? ST_TEST :
                                (r_row == 2'd1) ? ST_DPREP : ST_MUL;
            ST_TEST:  n_state = w_vis ? ST_MUL : ST_OUT;
            ST_DPREP: n_state = ST_DIV;
            ST_DIV:   n_state = (r_cnt == CNW'(1)) ? ST_MAP : ST_DIV;
            ST_MAP:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_OUT;
            ST_OUT:   n_state = w_slot ? ST_IDLE : ST_OUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_head_pop = (r_state == ST_IDLE) && i_head_valid;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_pos_x <= i_head.pos_x;
                r_pos_y <= i_head.pos_y;
                r_pos_z <= i_head.pos_z;
                r_row   <= 2'd3;
                r_k     <= 2'd0;
                r_acc   <= '0;
            end
            ST_MUL: begin
                r_prod <= w_pos * w_coef;
            end
            ST_ACC: begin
                r_acc <= r_acc + CW'(r_prod);
                r_k   <= r_k + 2'd1;
            end
            ST_TRANS: begin
                case (r_row)
                    2'd3:    r_cw <= w_clip;
                    2'd0:    r_cx <= w_clip;
                    default: r_cy <= w_clip;
                endcase
                r_row <= (r_row == 2'd3) ? 2'd0 : r_row + 2'd1;
                r_k   <= 2'd0;
                r_acc <= '0;
            end
            ST_TEST: begin
                r_res_vis <= 1'b0;
                r_res_x   <= '0;
                r_res_y   <= '0;
            end
            ST_DPREP: begin
                r_rx   <= DW'(w_magx) << FRAC_BITS;
                r_ry   <= DW'(w_magy) << FRAC_BITS;
                r_negx <= r_cx[CW-1];
                r_negy <= r_cy[CW-1];
                r_wsh  <= DW'(r_cw) << NDC_BITS;
                r_qx   <= '0;
                r_qy   <= '0;
                r_cnt  <= CNW'(NDC_BITS + 1);
            end
            ST_DIV: begin
                if (w_bx) begin
                    r_rx <= r_rx - r_wsh;
                end
                if (w_by) begin
                    r_ry <= r_ry - r_wsh;
                end
                r_qx  <= {r_qx[NDC_BITS-1:0], w_bx};
                r_qy  <= {r_qy[NDC_BITS-1:0], w_by};
                r_wsh <= r_wsh >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            ST_MAP: begin
                r_px <= PRW'(w_hw) * PRW'(w_nx);
                r_py <= PRW'(w_hh) * PRW'(w_ny);
            end
            ST_SUM: begin
                r_res_vis <= 1'b1;
                r_res_x   <= sat32(w_sx);
                r_res_y   <= sat32(w_sy);
            end
            default: begin
            end
        endcase
        if (r_state == ST_OUT && w_slot) begin
            r_ovis <= r_res_vis;
            r_ox   <= r_res_x;
            r_oy   <= r_res_y;
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            for (int i = 0; i < COEF_COUNT; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && w_slot) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            if (o_head_pop && i_head.operation == OP_LOAD) begin
                r_coef[i_head.coef_index] <= i_head.coef_value;
            end
        end
    end

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_ovis) |-> (r_ox == 0 && r_oy == 0))
        else $error("hidden point with non-zero coordinates");
    a_div_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DPREP) |-> (r_cw > 0))
        else $error("division entered with non-positive w");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_pop) |=> (r_ov && $stable(r_ox) && $stable(r_oy)))
        else $error("waiting result overwritten");

endmodule
`default_nettype wire

FILE: tb/tb_perspective_point_projection.sv
// Self-checking testbench of perspective_point_projection: directed table, then
// phases of random matrix loads and point projections under several viewports.
// Depends on ppp_pkg and the block's RTL; needs no files or arguments.
`default_nettype none
module tb_perspective_point_projection;
    import ppp_pkg::*;

    localparam int FRAC       = 16;
    localparam int DRAIN_WAIT = 100;    // settle time after the queue drains
    localparam int IDLE_LIMIT = 20000;  // cycles with no beat on either side
    localparam int HOLD_LEN   = 800;    // long receiver hold-off
    localparam int PHASE_ITEMS = 320;

    typedef struct {
        logic        vis;
        logic [31:0] sx;
        logic [31:0] sy;
    } t_screen;

    // One row of the directed table: either an item or a register write.
    typedef struct {
        bit          is_cfg;
        logic [1:0]  cfg_idx;
        logic [16:0] cfg_val;
        t_item       it;
        bit          typed;
        t_screen     want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic              i_operation;
    logic [3:0]        i_coef_index;
    logic signed [31:0] i_coef_value;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_pos_z;
    logic              empty;
    logic              pop;
    logic              o_visible;
    logic signed [31:0] o_screen_x;
    logic signed [31:0] o_screen_y;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;

    perspective_point_projection u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_operation  (i_operation),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .empty        (empty),
        .pop          (pop),
        .o_visible    (o_visible),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Predictor state: own copy of the matrix and of the registers.
    logic signed [31:0] matrix [COEF_COUNT];
    logic [13:0]        width_px;
    logic [13:0]        height_px;
    logic [16:0]        near_w;

    t_screen pending_screen [$];
    t_row    rows [$];
    int      errors;
    int      beats_out;
    int      idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end the run when no beat moves for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom % 16;
        if (r < 8) return 0;
        if (r < 14) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Clip row r: exact sum of products, floored to FRAC bits, plus translation.
    function automatic logic signed [71:0] clip_row_of(int r, t_item it);
        logic signed [71:0] acc;
        acc = 72'(it.pos_x) * 72'(matrix[r]) + 72'(it.pos_y) * 72'(matrix[4 + r])
            + 72'(it.pos_z) * 72'(matrix[8 + r]);
        return (acc >>> FRAC) + 72'(matrix[12 + r]);
    endfunction

    // num / w with FRAC fraction bits, truncated, magnitude capped at 2^40.
    function automatic logic signed [71:0] ndc_of_clip(logic signed [71:0] num,
                                                       logic signed [71:0] w);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (num < 0) ? 128'(-num) : 128'(num);
        q = mag / 128'(w);
        if (q >= (128'd1 << (NDC_BITS - FRAC)))
            q = 128'd1 << NDC_BITS;
        else
            q = (mag << FRAC) / 128'(w);
        return (num < 0) ? -72'(q) : 72'(q);
    endfunction

    function automatic logic [31:0] clamp32(logic signed [71:0] v);
        if (v > 72'sd2147483647) return 32'h7fff_ffff;
        if (v < -72'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_screen project_point(t_item it);
        t_screen s;
        logic signed [71:0] cw, nx, ny, hw, hh;
        cw = clip_row_of(3, it);
        s = '{1'b0, 32'd0, 32'd0};
        if (cw < $signed({55'd0, near_w}) || cw <= 0) return s;
        nx = ndc_of_clip(clip_row_of(0, it), cw);
        ny = ndc_of_clip(clip_row_of(1, it), cw);
        hw = 72'(width_px / 2);
        hh = 72'(height_px / 2);
        s.vis = 1'b1;
        s.sx  = clamp32(hw * nx + (hw <<< FRAC));
        s.sy  = clamp32((hh <<< FRAC) - hh * ny);
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h (beat %0d)", what, got, want,
                 beats_out);
        errors++;
    endtask

    // Append one row to the directed table.
    task automatic add_row(t_row row);
        rows.insert(rows.size(), row);
    endtask

    // Update the matrix for a load; queue the predicted (or typed) screen point.
    task automatic take_item(t_item it, bit typed, t_screen want);
        if (it.operation == OP_LOAD) begin
            matrix[it.coef_index] = it.coef_value;
        end else begin
            pending_screen.insert(pending_screen.size(), typed ? want : project_point(it));
        end
    endtask

    task automatic push_item(t_item it, bit typed, t_screen want);
        int g;
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_operation  <= it.operation;
        i_coef_index <= it.coef_index;
        i_coef_value <= it.coef_value;
        i_pos_x      <= it.pos_x;
        i_pos_y      <= it.pos_y;
        i_pos_z      <= it.pos_z;
        do @(posedge i_clk); while (full);
        take_item(it, typed, want);
    endtask

    // Wait until every queued point has come back, then let the block settle.
    task automatic drain();
        push <= 1'b0;
        while (pending_screen.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SCREEN_WIDTH:  width_px  = val[13:0];
            CFG_SCREEN_HEIGHT: height_px = val[13:0];
            CFG_NEAR_LIMIT:    near_w    = val;
            default: ;
        endcase
    endtask

    // Q16.16 value: often moderate, sometimes tiny, whole or full range.
    function automatic logic [31:0] rand_fixed();
        case ($urandom % 5)
            0, 1:    return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
            2:       return 32'($urandom_range(0, 7));
            3:       return 32'($urandom_range(0, 8)) << FRAC;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item rand_item(logic op);
        t_item it;
        it.operation  = op;
        it.coef_index = 4'($urandom_range(0, 15));
        it.coef_value = rand_fixed();
        it.pos_x      = rand_fixed();
        it.pos_y      = rand_fixed();
        it.pos_z      = rand_fixed();
        // Keep the w translation mostly positive so that points come out visible.
        if (op == OP_LOAD && it.coef_index == 4'd15 && ($urandom % 4) != 0)
            it.coef_value = $urandom_range(1, 32'h0008_0000);
        return it;
    endfunction

    function automatic t_item mk_load(int idx, logic [31:0] val);
        t_item it;
        it = '0;
        it.operation  = OP_LOAD;
        it.coef_index = idx[3:0];
        it.coef_value = val;
        return it;
    endfunction

    function automatic t_item mk_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_item it;
        it = '0;
        it.operation = OP_PROJECT;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        return it;
    endfunction

    // Receiver: random gaps, one long hold-off while the sender keeps offering.
    initial begin
        t_screen want;
        int      g;
        bit      held;
        pop  <= 1'b0;
        held = 1'b0;
        beats_out = 0;
        @(posedge i_clk iff i_rst_n);
        pop <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                beats_out++;
                if (pending_screen.size() == 0) begin
                    $display("unexpected result beat %0d", beats_out);
                    errors++;
                end else begin
                    want = pending_screen.pop_front();
                    if (o_visible !== want.vis)
                        report_mismatch("visible", 32'(o_visible), 32'(want.vis));
                    if (o_screen_x !== want.sx)
                        report_mismatch("screen_x", o_screen_x, want.sx);
                    if (o_screen_y !== want.sy)
                        report_mismatch("screen_y", o_screen_y, want.sy);
                end
                g = (!held && beats_out == 150) ? HOLD_LEN : gap_len();
                if (beats_out == 150) held = 1'b1;
                if (g > 0) begin
                    pop <= 1'b0;
                    repeat (g) @(posedge i_clk);
                    pop <= 1'b1;
                end
            end
        end
    end

    // Sender: reset, directed table, then random phases.
    initial begin
        t_screen none;
        t_item   it;
        int      sent;
        int      burst;
        errors       = 0;
        idle_cycles  = 0;
        none         = '{1'b0, 32'd0, 32'd0};
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_operation  <= OP_LOAD;
        i_coef_index <= '0;
        i_coef_value <= '0;
        i_pos_x      <= '0;
        i_pos_y      <= '0;
        i_pos_z      <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        foreach (matrix[k]) matrix[k] = '0;
        width_px  = RST_SCREEN_WIDTH;
        height_px = RST_SCREEN_HEIGHT;
        near_w    = RST_NEAR_LIMIT;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero matrix after reset: w is 0, so the point is hidden.
        add_row('{1'b0, 2'd0, 17'd0, mk_point(32'h0001_0000, 32'h0002_0000, 0), 1'b1,
                  none});
        add_row('{1'b0, 2'd0, 17'd0, mk_load(15, 32'h0001_0000), 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_load(0, 32'h0001_0000), 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_load(5, 32'h0001_0000), 1'b0, none});
        // Unit x and y scale with w = 1: the origin lands in the centre of a 1024x768 view.
        add_row('{1'b0, 2'd0, 17'd0, mk_point(0, 0, 0), 1'b1,
                  '{1'b1, 32'd33554432, 32'd25165824}});
        // Extremes of the coordinates saturate both axes.
        add_row('{1'b0, 2'd0, 17'd0,
                  mk_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000), 1'b1,
                  '{1'b1, 32'h7fff_ffff, 32'h8000_0000}});
        add_row('{1'b0, 2'd0, 17'd0, mk_point(32'h8000_0000, 32'h8000_0000, 0), 1'b1,
                  '{1'b1, 32'h8000_0000, 32'h7fff_ffff}});
        // Negative w behind the viewer: hidden.
        add_row('{1'b0, 2'd0, 17'd0, mk_load(11, 32'h8000_0000), 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_point(0, 0, 32'h7fff_ffff), 1'b1, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_load(11, 32'h7fff_ffff), 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0,
                  mk_point(32'h0001_0000, 32'hffff_0000, 32'h0001_0000), 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_load(11, 0), 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_load(3, 32'hffff_0000), 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_point(32'h0003_0000, 0, 0), 1'b1, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_load(3, 0), 1'b0, none});
        // w exactly at the near limit is visible, one below is hidden.
        add_row('{1'b0, 2'd0, 17'd0, mk_load(15, 32'd6554), 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_point(32'h0000_1000, 32'hffff_f000, 0), 1'b0,
                  none});
        add_row('{1'b0, 2'd0, 17'd0, mk_load(15, 32'd6553), 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_point(0, 0, 0), 1'b1, none});
        // Near limit 0 with w of zero: still hidden, no division by zero.
        add_row('{1'b1, CFG_NEAR_LIMIT, 17'd0, '0, 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_load(15, 0), 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_point(0, 0, 0), 1'b1, none});
        // Tiny w and a huge x: the quotient hits its cap.
        add_row('{1'b0, 2'd0, 17'd0, mk_load(15, 32'd1), 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_point(32'h7fff_0000, 32'h8000_0000, 0), 1'b0,
                  none});
        // Zero width: the x axis collapses to 0.
        add_row('{1'b1, CFG_SCREEN_WIDTH, 17'd0, '0, 1'b0, none});
        add_row('{1'b0, 2'd0, 17'd0, mk_point(32'h0001_0000, 32'h0001_0000, 0), 1'b0,
                  none});

        foreach (rows[r]) begin
            if (rows[r].is_cfg) begin
                drain();
                write_reg(rows[r].cfg_idx, rows[r].cfg_val);
            end else begin
                push_item(rows[r].it, rows[r].typed, rows[r].want);
            end
        end

        // Random phases; each starts from an idle block with new registers.
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(CFG_SCREEN_WIDTH, 17'd8192);
                    write_reg(CFG_SCREEN_HEIGHT, 17'd8192);
                    write_reg(CFG_NEAR_LIMIT, 17'd0);
                end
                1: begin
                    write_reg(CFG_SCREEN_WIDTH, 17'd1);
                    write_reg(CFG_SCREEN_HEIGHT, 17'd1);
                    write_reg(CFG_NEAR_LIMIT, 17'd65536);
                end
                2: begin
                    write_reg(CFG_SCREEN_WIDTH, 17'h3fff);
                    write_reg(CFG_SCREEN_HEIGHT, 17'd0);
                    write_reg(CFG_NEAR_LIMIT, 17'h1ffff);
                end
                3: begin
                    write_reg(CFG_SCREEN_WIDTH, 17'd1024);
                    write_reg(CFG_SCREEN_HEIGHT, 17'd768);
                    write_reg(CFG_NEAR_LIMIT, 17'd1);
                end
                default: begin
                    write_reg(CFG_SCREEN_WIDTH, 17'($urandom));
                    write_reg(CFG_SCREEN_HEIGHT, 17'($urandom));
                    write_reg(CFG_NEAR_LIMIT, 17'($urandom));
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (($urandom % 8) == 0) begin
                    // Noise: any operation, any content.
                    it = rand_item(1'($urandom));
                    it.coef_value = $urandom;
                    it.pos_x = $urandom;
                    push_item(it, 1'b0, none);
                    sent++;
                end else begin
                    // Well-formed: a few coefficient loads, then some points.
                    burst = $urandom_range(0, 4);
                    repeat (burst) begin
                        push_item(rand_item(OP_LOAD), 1'b0, none);
                        sent++;
                    end
                    burst = $urandom_range(1, 3);
                    repeat (burst) begin
                        push_item(rand_item(OP_PROJECT), 1'b0, none);
                        sent++;
                    end
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
sv/ppp_pkg.sv
sv/ppp_front.sv
sv/ppp_back.sv
sv/perspective_point_projection.sv
tb/tb_perspective_point_projection.sv
